// ----- design/rar_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rar_pkg
// Shared types and codes for the rational arithmetic reduce block.
// ---------------------------------------------------------------------------
package rar_pkg;

    localparam int PORT_W = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_UNDEF = 2'd1,
        STAT_OVF   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        DIV_FA  = 2'd0,
        DIV_FB  = 2'd1,
        DIV_NUM = 2'd2,
        DIV_DEN = 2'd3
    } div_sel_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_GCD_LOAD0,
        CMD_GCD_LOAD1,
        CMD_GCD_STEP,
        CMD_GCD_SHIFT,
        CMD_DIV_LOAD,
        CMD_DIV_STEP,
        CMD_DIV_STORE,
        CMD_MUL_FA,
        CMD_MUL_FB,
        CMD_MUL_DEN,
        CMD_COMBINE,
        CMD_MUL_N,
        CMD_MUL_D,
        CMD_OUT_UNDEF,
        CMD_OUT_PACK
    } dp_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_UNDEF,
        ST_G_LOAD,
        ST_G_RUN,
        ST_G_SHIFT,
        ST_D_LOAD,
        ST_D_RUN,
        ST_D_STORE,
        ST_M_FA,
        ST_M_FB,
        ST_M_DEN,
        ST_COMBINE,
        ST_M_N,
        ST_M_D,
        ST_FIN_CHECK
    } state_t;

    typedef struct packed {
        dp_cmd_t  cmd;
        div_sel_t div_sel;
    } dp_ctrl_t;

    typedef struct packed {
        logic in_zero_den;
        logic is_addsub;
        logic gcd_done;
        logic k_zero;
        logic div_done;
        logic den_zero;
    } dp_stat_t;

endpackage

// ----- design/rar_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rar_datapath
// Operand registers, binary gcd unit, restoring divider, multiplier and
// result packing, driven one command per cycle by the controller.
// ---------------------------------------------------------------------------
module rar_datapath #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          aclk,
    input  rar_pkg::dp_ctrl_t             ctrl,
    output rar_pkg::dp_stat_t             stat,
    input  logic [1:0]                    in_opcode,
    input  logic [rar_pkg::PORT_W-1:0]    in_a_num,
    input  logic [rar_pkg::PORT_W-1:0]    in_a_den,
    input  logic [rar_pkg::PORT_W-1:0]    in_b_num,
    input  logic [rar_pkg::PORT_W-1:0]    in_b_den,
    output logic [rar_pkg::PORT_W-1:0]    res_num,
    output logic [rar_pkg::PORT_W-1:0]    res_den,
    output logic [1:0]                    status
);

    localparam int W2 = 2 * DATA_WIDTH;
    localparam int KW = $clog2(W2);
    localparam int CW = $clog2(W2 + 1);
    localparam logic [W2-1:0] LIM = W2'(1) << (DATA_WIDTH - 1);

    rar_pkg::opcode_t op_reg;
    logic an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [DATA_WIDTH-1:0] an_m_reg, ad_m_reg, bn_m_reg, bd_m_reg;
    logic [DATA_WIDTH-1:0] fa_m_reg, fb_m_reg;
    logic [W2-1:0] p1_m_reg, p2_m_reg, num_m_reg, den_m_reg;
    logic p1_s_reg, p2_s_reg, num_s_reg, den_s_reg;
    logic [W2-1:0] ga_reg, gb_reg, g_reg, rem_reg, quo_reg;
    logic [KW-1:0] gk_reg;
    logic [CW-1:0] cnt_reg;
    logic [rar_pkg::PORT_W-1:0] res_num_reg, res_den_reg;
    logic [1:0] status_reg;

    logic [DATA_WIDTH-1:0] an_x, ad_x, bn_x, bd_x;
    logic [DATA_WIDTH-1:0] mul_a, mul_b;
    logic [W2-1:0] prod;
    logic prod_nz;
    logic [W2:0] div_sh, div_diff;
    logic [W2-1:0] dividend;
    logic [W2-1:0] sum_m;
    logic sum_s;
    logic [W2-1:0] num_v, den_v;
    logic ovf;

    assign an_x = in_a_num[DATA_WIDTH-1:0];
    assign ad_x = in_a_den[DATA_WIDTH-1:0];
    assign bn_x = in_b_num[DATA_WIDTH-1:0];
    assign bd_x = in_b_den[DATA_WIDTH-1:0];

    always_comb begin
        case (ctrl.cmd)
            rar_pkg::CMD_MUL_FA: begin
                mul_a = an_m_reg;
                mul_b = fa_m_reg;
            end
            rar_pkg::CMD_MUL_FB: begin
                mul_a = bn_m_reg;
                mul_b = fb_m_reg;
            end
            rar_pkg::CMD_MUL_DEN: begin
                mul_a = fb_m_reg;
                mul_b = bd_m_reg;
            end
            rar_pkg::CMD_MUL_N: begin
                mul_a = an_m_reg;
                mul_b = (op_reg == rar_pkg::OP_MUL) ? bn_m_reg : bd_m_reg;
            end
            rar_pkg::CMD_MUL_D: begin
                mul_a = ad_m_reg;
                mul_b = (op_reg == rar_pkg::OP_MUL) ? bd_m_reg : bn_m_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = W2'(mul_a) * W2'(mul_b);
    assign prod_nz = (prod != '0);

    always_comb begin
        case (ctrl.div_sel)
            rar_pkg::DIV_FA:  dividend = W2'(bd_m_reg);
            rar_pkg::DIV_FB:  dividend = W2'(ad_m_reg);
            rar_pkg::DIV_NUM: dividend = num_m_reg;
            default:          dividend = den_m_reg;
        endcase
    end

    assign div_sh   = {rem_reg, quo_reg[W2-1]};
    assign div_diff = div_sh - {1'b0, g_reg};

    always_comb begin
        if (p1_s_reg == p2_s_reg) begin
            sum_m = p1_m_reg + p2_m_reg;
            sum_s = p1_s_reg;
        end else if (p1_m_reg >= p2_m_reg) begin
            sum_m = p1_m_reg - p2_m_reg;
            sum_s = p1_s_reg;
        end else begin
            sum_m = p2_m_reg - p1_m_reg;
            sum_s = p2_s_reg;
        end
        if (sum_m == '0) begin
            sum_s = 1'b0;
        end
    end

    assign num_v = num_s_reg ? (~num_m_reg + W2'(1)) : num_m_reg;
    assign den_v = den_s_reg ? (~den_m_reg + W2'(1)) : den_m_reg;
    assign ovf = (num_s_reg ? (num_m_reg > LIM) : (num_m_reg > LIM - W2'(1)))
              || (den_s_reg ? (den_m_reg > LIM) : (den_m_reg > LIM - W2'(1)));

    always_ff @(posedge aclk) begin
        case (ctrl.cmd)
            rar_pkg::CMD_CAPTURE: begin
                op_reg   <= rar_pkg::opcode_t'(in_opcode);
                an_s_reg <= an_x[DATA_WIDTH-1];
                ad_s_reg <= ad_x[DATA_WIDTH-1];
                bn_s_reg <= bn_x[DATA_WIDTH-1];
                bd_s_reg <= bd_x[DATA_WIDTH-1];
                an_m_reg <= an_x[DATA_WIDTH-1] ? (~an_x + DATA_WIDTH'(1)) : an_x;
                ad_m_reg <= ad_x[DATA_WIDTH-1] ? (~ad_x + DATA_WIDTH'(1)) : ad_x;
                bn_m_reg <= bn_x[DATA_WIDTH-1] ? (~bn_x + DATA_WIDTH'(1)) : bn_x;
                bd_m_reg <= bd_x[DATA_WIDTH-1] ? (~bd_x + DATA_WIDTH'(1)) : bd_x;
            end
            rar_pkg::CMD_GCD_LOAD0: begin
                ga_reg <= W2'(ad_m_reg);
                gb_reg <= W2'(bd_m_reg);
                gk_reg <= '0;
            end
            rar_pkg::CMD_GCD_LOAD1: begin
                ga_reg <= num_m_reg;
                gb_reg <= den_m_reg;
                gk_reg <= '0;
            end
            rar_pkg::CMD_GCD_STEP: begin
                if (ga_reg == '0 || gb_reg == '0) begin
                    g_reg <= ga_reg | gb_reg;
                end else if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_reg <= ga_reg >> 1;
                    gb_reg <= gb_reg >> 1;
                    gk_reg <= gk_reg + KW'(1);
                end else if (!ga_reg[0]) begin
                    ga_reg <= ga_reg >> 1;
                end else if (!gb_reg[0]) begin
                    gb_reg <= gb_reg >> 1;
                end else if (ga_reg >= gb_reg) begin
                    ga_reg <= ga_reg - gb_reg;
                end else begin
                    gb_reg <= gb_reg - ga_reg;
                end
            end
            rar_pkg::CMD_GCD_SHIFT: begin
                g_reg  <= g_reg << 1;
                gk_reg <= gk_reg - KW'(1);
            end
            rar_pkg::CMD_DIV_LOAD: begin
                rem_reg <= '0;
                quo_reg <= dividend;
                cnt_reg <= '0;
            end
            rar_pkg::CMD_DIV_STEP: begin
                if (!div_diff[W2]) begin
                    rem_reg <= div_diff[W2-1:0];
                    quo_reg <= {quo_reg[W2-2:0], 1'b1};
                end else begin
                    rem_reg <= div_sh[W2-1:0];
                    quo_reg <= {quo_reg[W2-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + CW'(1);
            end
            rar_pkg::CMD_DIV_STORE: begin
                case (ctrl.div_sel)
                    rar_pkg::DIV_FA:  fa_m_reg  <= quo_reg[DATA_WIDTH-1:0];
                    rar_pkg::DIV_FB:  fb_m_reg  <= quo_reg[DATA_WIDTH-1:0];
                    rar_pkg::DIV_NUM: num_m_reg <= quo_reg;
                    default:          den_m_reg <= quo_reg;
                endcase
            end
            rar_pkg::CMD_MUL_FA: begin
                p1_m_reg <= prod;
                p1_s_reg <= (an_s_reg ^ ad_s_reg) && prod_nz;
            end
            rar_pkg::CMD_MUL_FB: begin
                p2_m_reg <= prod;
                p2_s_reg <= ((bn_s_reg ^ bd_s_reg) ^ (op_reg == rar_pkg::OP_SUB)) && prod_nz;
            end
            rar_pkg::CMD_MUL_DEN: begin
                den_m_reg <= prod;
                den_s_reg <= 1'b0;
            end
            rar_pkg::CMD_COMBINE: begin
                num_m_reg <= sum_m;
                num_s_reg <= sum_s;
            end
            rar_pkg::CMD_MUL_N: begin
                num_m_reg <= prod;
                num_s_reg <= (an_s_reg ^ ((op_reg == rar_pkg::OP_MUL) ? bn_s_reg : bd_s_reg))
                             && prod_nz;
            end
            rar_pkg::CMD_MUL_D: begin
                den_m_reg <= prod;
                den_s_reg <= (ad_s_reg ^ ((op_reg == rar_pkg::OP_MUL) ? bd_s_reg : bn_s_reg))
                             && prod_nz;
            end
            rar_pkg::CMD_OUT_UNDEF: begin
                res_num_reg <= '0;
                res_den_reg <= '0;
                status_reg  <= rar_pkg::STAT_UNDEF;
            end
            rar_pkg::CMD_OUT_PACK: begin
                res_num_reg <= rar_pkg::PORT_W'($signed(num_v[DATA_WIDTH-1:0]));
                res_den_reg <= rar_pkg::PORT_W'($signed(den_v[DATA_WIDTH-1:0]));
                status_reg  <= ovf ? rar_pkg::STAT_OVF : rar_pkg::STAT_OK;
            end
            default: begin
            end
        endcase
    end

    assign stat.in_zero_den = (ad_m_reg == '0) || (bd_m_reg == '0);
    assign stat.is_addsub   = (op_reg == rar_pkg::OP_ADD) || (op_reg == rar_pkg::OP_SUB);
    assign stat.gcd_done    = (ga_reg == '0) || (gb_reg == '0);
    assign stat.k_zero      = (gk_reg == '0);
    assign stat.div_done    = (cnt_reg == CW'(W2));
    assign stat.den_zero    = (den_m_reg == '0);

    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign status  = status_reg;

endmodule

// ----- design/rar_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rar_ctrl
// Sequencer for the reduce datapath: handshakes, operation order and the
// result valid flag.
// ---------------------------------------------------------------------------
module rar_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output rar_pkg::dp_ctrl_t ctrl,
    input  rar_pkg::dp_stat_t stat
);

    rar_pkg::state_t   state_reg, state_next;
    rar_pkg::div_sel_t dsel_reg, dsel_next;
    logic fin_reg, fin_next;
    logic m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rar_pkg::ST_IDLE;
            dsel_reg    <= rar_pkg::DIV_FA;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dsel_reg    <= dsel_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        dsel_next    = dsel_reg;
        fin_next     = fin_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        ctrl.cmd     = rar_pkg::CMD_NONE;
        ctrl.div_sel = dsel_reg;
        case (state_reg)
            rar_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.cmd   = rar_pkg::CMD_CAPTURE;
                    state_next = rar_pkg::ST_CHECK;
                end
            end
            rar_pkg::ST_CHECK: begin
                if (stat.in_zero_den) begin
                    state_next = rar_pkg::ST_UNDEF;
                end else if (stat.is_addsub) begin
                    fin_next   = 1'b0;
                    state_next = rar_pkg::ST_G_LOAD;
                end else begin
                    state_next = rar_pkg::ST_M_N;
                end
            end
            rar_pkg::ST_UNDEF: begin
                if (!(m_valid_reg && !m_ready)) begin
                    ctrl.cmd     = rar_pkg::CMD_OUT_UNDEF;
                    m_valid_next = 1'b1;
                    state_next   = rar_pkg::ST_IDLE;
                end
            end
            rar_pkg::ST_G_LOAD: begin
                ctrl.cmd   = fin_reg ? rar_pkg::CMD_GCD_LOAD1 : rar_pkg::CMD_GCD_LOAD0;
                state_next = rar_pkg::ST_G_RUN;
            end
            rar_pkg::ST_G_RUN: begin
                ctrl.cmd = rar_pkg::CMD_GCD_STEP;
                if (stat.gcd_done) begin
                    state_next = rar_pkg::ST_G_SHIFT;
                end
            end
            rar_pkg::ST_G_SHIFT: begin
                if (stat.k_zero) begin
                    dsel_next  = fin_reg ? rar_pkg::DIV_NUM : rar_pkg::DIV_FA;
                    state_next = rar_pkg::ST_D_LOAD;
                end else begin
                    ctrl.cmd = rar_pkg::CMD_GCD_SHIFT;
                end
            end
            rar_pkg::ST_D_LOAD: begin
                ctrl.cmd   = rar_pkg::CMD_DIV_LOAD;
                state_next = rar_pkg::ST_D_RUN;
            end
            rar_pkg::ST_D_RUN: begin
                if (stat.div_done) begin
                    state_next = rar_pkg::ST_D_STORE;
                end else begin
                    ctrl.cmd = rar_pkg::CMD_DIV_STEP;
                end
            end
            rar_pkg::ST_D_STORE: begin
                case (dsel_reg)
                    rar_pkg::DIV_FA: begin
                        ctrl.cmd   = rar_pkg::CMD_DIV_STORE;
                        dsel_next  = rar_pkg::DIV_FB;
                        state_next = rar_pkg::ST_D_LOAD;
                    end
                    rar_pkg::DIV_FB: begin
                        ctrl.cmd   = rar_pkg::CMD_DIV_STORE;
                        state_next = rar_pkg::ST_M_FA;
                    end
                    rar_pkg::DIV_NUM: begin
                        ctrl.cmd   = rar_pkg::CMD_DIV_STORE;
                        dsel_next  = rar_pkg::DIV_DEN;
                        state_next = rar_pkg::ST_D_LOAD;
                    end
                    default: begin
                        // hold the last quotient until the output stage frees up
                        if (!(m_valid_reg && !m_ready)) begin
                            ctrl.cmd   = rar_pkg::CMD_DIV_STORE;
                            dsel_next  = rar_pkg::DIV_FA;
                            state_next = rar_pkg::ST_FIN_CHECK;
                            fin_next   = 1'b1;
                        end
                    end
                endcase
            end
            rar_pkg::ST_M_FA: begin
                ctrl.cmd   = rar_pkg::CMD_MUL_FA;
                state_next = rar_pkg::ST_M_FB;
            end
            rar_pkg::ST_M_FB: begin
                ctrl.cmd   = rar_pkg::CMD_MUL_FB;
                state_next = rar_pkg::ST_M_DEN;
            end
            rar_pkg::ST_M_DEN: begin
                ctrl.cmd   = rar_pkg::CMD_MUL_DEN;
                state_next = rar_pkg::ST_COMBINE;
            end
            rar_pkg::ST_COMBINE: begin
                ctrl.cmd   = rar_pkg::CMD_COMBINE;
                fin_next   = 1'b0;
                state_next = rar_pkg::ST_FIN_CHECK;
            end
            rar_pkg::ST_M_N: begin
                ctrl.cmd   = rar_pkg::CMD_MUL_N;
                state_next = rar_pkg::ST_M_D;
            end
            rar_pkg::ST_M_D: begin
                ctrl.cmd   = rar_pkg::CMD_MUL_D;
                fin_next   = 1'b0;
                state_next = rar_pkg::ST_FIN_CHECK;
            end
            rar_pkg::ST_FIN_CHECK: begin
                if (fin_reg) begin
                    // reduced pair ready: pack into the output register
                    ctrl.cmd     = rar_pkg::CMD_OUT_PACK;
                    m_valid_next = 1'b1;
                    fin_next     = 1'b0;
                    state_next   = rar_pkg::ST_IDLE;
                end else if (stat.den_zero) begin
                    state_next = rar_pkg::ST_UNDEF;
                end else begin
                    fin_next   = 1'b1;
                    state_next = rar_pkg::ST_G_LOAD;
                end
            end
            default: begin
                state_next = rar_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- design/rational_arith_reduce.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rational_arith_reduce
// Exact add, subtract, multiply or divide of two signed fractions, reduced
// by the gcd of the result magnitudes, with ok, undefined and overflow status.
// ---------------------------------------------------------------------------
// One transaction is worked at a time; a finished result sits in the output
// register while the next transaction is accepted and worked. With W equal to
// 2*DATA_WIDTH, a transaction takes a setup, one binary gcd run (one subtract
// or shift per cycle, then one left shift per common factor of two) and two
// restoring divisions of W quotient bits each; add and subtract run this twice,
// the first time on the denominators. A zero input denominator skips straight
// to the undefined status. The run time is set by the shared gcd unit and the
// one-bit-per-cycle divider.
module rational_arith_reduce #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_a_num,
    input  logic [31:0] s_a_den,
    input  logic [31:0] s_b_num,
    input  logic [31:0] s_b_den,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_res_num,
    output logic [31:0] m_res_den,
    output logic [1:0]  m_status
);

    rar_pkg::dp_ctrl_t ctrl;
    rar_pkg::dp_stat_t stat;

    rar_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl),
        .stat    (stat)
    );

    rar_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_opcode (s_opcode),
        .in_a_num  (s_a_num),
        .in_a_den  (s_a_den),
        .in_b_num  (s_b_num),
        .in_b_den  (s_b_den),
        .res_num   (m_res_num),
        .res_den   (m_res_den),
        .status    (m_status)
    );

endmodule
